>>> hdl/upd_pkg.sv
// ---------------------------------------------------------------------------
// upd_pkg
// shared types and constants of the uart packet deframer
// ---------------------------------------------------------------------------
package upd_pkg;

   localparam int PAYLOAD_DEPTH = 32;
   localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
   localparam int ADDR_W        = IDX_W + 1;
   localparam int MEM_DEPTH     = 2 ** ADDR_W;
   localparam int LEN_W         = 6;
   localparam int CSR_IDX_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_ONE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TWO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OK_TYPE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_EN = 3'd5;

   typedef struct packed {
      logic [7:0]       packet_type;
      logic [LEN_W-1:0] length;
      logic             confirm;
      logic             bank;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

endpackage

>>> hdl/upd_front.sv
// ---------------------------------------------------------------------------
// upd_front
// frame parser: hunts start bytes, checks header, stores payload, queues
// a descriptor on a matching trailer
// ---------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 q_full,
   output logic                 q_push,
   output desc_type             q_desc,
   output mem_wr_type           mem_wr
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_START2  = 3'd1;
   localparam logic [2:0] PH_TYPE    = 3'd2;
   localparam logic [2:0] PH_LENGTH  = 3'd3;
   localparam logic [2:0] PH_DATA    = 3'd4;
   localparam logic [2:0] PH_TRAILER = 3'd5;

   logic [7:0]       start_one_ff, start_two_ff, trailer_ff, ok_type_ff;
   logic [LEN_W-1:0] max_len_ff;
   logic             confirm_en_ff;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       held_start_two_ff, held_start_two_in;
   logic [7:0]       held_type_ff, held_type_in;
   logic [LEN_W-1:0] held_length_ff, held_length_in;
   logic [LEN_W-1:0] taken_ff, taken_in;
   logic             wbank_ff, wbank_in;
   logic             accept;
   logic             len_bad;

   assign csr_ready = 1'b1;
   // the bank being filled must not still be in the queue
   assign req_ready = !(((phase_ff == PH_DATA) || (phase_ff == PH_TRAILER)) && q_full);
   assign accept    = req_valid && req_ready;

   assign len_bad = (req_rx_byte > {2'b00, max_len_ff}) ||
                    ({24'd0, req_rx_byte} > 32'(PAYLOAD_DEPTH));

   always_comb begin
      phase_in          = phase_ff;
      held_start_two_in = held_start_two_ff;
      held_type_in      = held_type_ff;
      held_length_in    = held_length_ff;
      taken_in          = taken_ff;
      wbank_in          = wbank_ff;
      q_push            = 1'b0;
      q_desc.packet_type = held_type_ff;
      q_desc.length     = held_length_ff;
      q_desc.confirm    = confirm_en_ff && (held_type_ff == ok_type_ff);
      q_desc.bank       = wbank_ff;
      mem_wr.en         = 1'b0;
      mem_wr.addr       = {wbank_ff, taken_ff[IDX_W-1:0]};
      mem_wr.data       = req_rx_byte;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == start_one_ff) phase_in = PH_START2;
            end
            PH_START2: begin
               held_start_two_in = req_rx_byte;
               phase_in          = PH_TYPE;
            end
            PH_TYPE: begin
               held_type_in = req_rx_byte;
               phase_in     = PH_LENGTH;
            end
            PH_LENGTH: begin
               if ((held_start_two_ff != start_two_ff) || len_bad) begin
                  phase_in = PH_HUNT;
               end else begin
                  held_length_in = req_rx_byte[LEN_W-1:0];
                  taken_in       = '0;
                  phase_in       = (req_rx_byte == 8'd0) ? PH_TRAILER : PH_DATA;
               end
            end
            PH_DATA: begin
               mem_wr.en = ({26'd0, taken_ff} < 32'(PAYLOAD_DEPTH));
               taken_in  = taken_ff + LEN_W'(1);
               if (taken_in >= held_length_ff) phase_in = PH_TRAILER;
            end
            PH_TRAILER: begin
               if (req_rx_byte == trailer_ff) begin
                  q_push   = 1'b1;
                  wbank_in = !wbank_ff;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         held_start_two_ff <= '0;
         held_type_ff      <= '0;
         held_length_ff    <= '0;
         taken_ff          <= '0;
         wbank_ff          <= 1'b0;
         start_one_ff      <= 8'd85;
         start_two_ff      <= 8'd170;
         trailer_ff        <= 8'd69;
         max_len_ff        <= LEN_W'(23);
         ok_type_ff        <= 8'd0;
         confirm_en_ff     <= 1'b1;
      end else begin
         phase_ff          <= phase_in;
         held_start_two_ff <= held_start_two_in;
         held_type_ff      <= held_type_in;
         held_length_ff    <= held_length_in;
         taken_ff          <= taken_in;
         wbank_ff          <= wbank_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_START_ONE:  start_one_ff  <= csr_data[7:0];
               CSR_START_TWO:  start_two_ff  <= csr_data[7:0];
               CSR_TRAILER:    trailer_ff    <= csr_data[7:0];
               CSR_MAX_LENGTH: max_len_ff    <= csr_data[LEN_W-1:0];
               CSR_OK_TYPE:    ok_type_ff    <= csr_data[7:0];
               CSR_CONFIRM_EN: confirm_en_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

>>> hdl/upd_desc_queue.sv
// ---------------------------------------------------------------------------
// upd_desc_queue
// two-entry queue of released frame descriptors
// ---------------------------------------------------------------------------
module upd_desc_queue import upd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head_desc,
   output logic     full
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

>>> hdl/upd_back.sv
// ---------------------------------------------------------------------------
// upd_back
// payload store and result sequencer: plays one queued frame out as a
// run of result words
// ---------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  mem_wr_type       mem_wr,
   input  logic             head_valid,
   input  desc_type         head_desc,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_packet_type,
   output logic [LEN_W-1:0] rsp_payload_length,
   output logic [4:0]       rsp_payload_index,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_has_payload,
   output logic             rsp_is_confirmation,
   output logic             rsp_last
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_LOAD  = 2'd2;

   logic [7:0]       mem [MEM_DEPTH];
   logic [7:0]       rd_data_ff;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic             load;
   logic             has;
   logic             is_last;

   logic [7:0]       type_ff;
   logic [LEN_W-1:0] len_ff;
   logic [4:0]       index_ff;
   logic [7:0]       byte_ff;
   logic             has_ff, conf_ff, last_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
      rd_data_ff <= mem[{head_desc.bank, idx_ff}];
   end

   assign has     = (head_desc.length != '0);
   assign is_last = !has || (({1'b0, idx_ff} + LEN_W'(1)) == head_desc.length);
   assign load    = (state_ff == S_LOAD) && (!valid_ff || rsp_ready);
   assign pop     = load && is_last;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      case (state_ff)
         // idx is already zero here, so the first read is under way
         S_IDLE: begin
            if (head_valid) state_in = S_LOAD;
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (load) begin
               valid_in = 1'b1;
               if (is_last) begin
                  idx_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         type_ff  <= head_desc.packet_type;
         len_ff   <= head_desc.length;
         index_ff <= 5'(idx_ff);
         byte_ff  <= has ? rd_data_ff : 8'd0;
         has_ff   <= has;
         conf_ff  <= head_desc.confirm;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_packet_type     = type_ff;
   assign rsp_payload_length  = len_ff;
   assign rsp_payload_index   = index_ff;
   assign rsp_payload_byte    = byte_ff;
   assign rsp_has_payload     = has_ff;
   assign rsp_is_confirmation = conf_ff;
   assign rsp_last            = last_ff;

endmodule

>>> hdl/uart_packet_deframer_unit.sv
// ---------------------------------------------------------------------------
// uart_packet_deframer_unit
// recovers start/type/length/payload/trailer frames from received bytes
// and releases each good frame as a run of result words
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid/req_ready    rx_byte
//  rsp_      out        rsp_valid/rsp_ready    type, length, index, byte, flags
//  csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
//  a received byte is taken in one cycle; payload and trailer bytes wait
//  while both payload banks hold frames not yet played out
//  a released frame plays out as result words; between words the sequencer
//  steps through S_FETCH, waiting on the registered read of the payload store
//  synchronous reset clears control state and loads register defaults
//  a stalled rsp_ready holds the output word and the sequencer only
// ---------------------------------------------------------------------------
module uart_packet_deframer_unit import upd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_packet_type,
   output logic [LEN_W-1:0]     rsp_payload_length,
   output logic [4:0]           rsp_payload_index,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_has_payload,
   output logic                 rsp_is_confirmation,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   logic       q_full, q_push, q_pop, q_head_valid;
   desc_type   q_desc, q_head;
   mem_wr_type mem_wr;

   upd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (q_desc),
      .mem_wr      (mem_wr)
   );

   upd_desc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_desc),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_desc  (q_head),
      .full       (q_full)
   );

   upd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .mem_wr              (mem_wr),
      .head_valid          (q_head_valid),
      .head_desc           (q_head),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_packet_type     (rsp_packet_type),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_has_payload     (rsp_has_payload),
      .rsp_is_confirmation (rsp_is_confirmation),
      .rsp_last            (rsp_last)
   );

endmodule

>>> tb/uart_packet_deframer_unit_tb.sv
// ---------------------------------------------------------------------------
// uart_packet_deframer_unit_tb
// drives received bytes into the deframer and predicts the frame words it
// releases; each released word is compared field by field in arrival order
// ---------------------------------------------------------------------------
module uart_packet_deframer_unit_tb import upd_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE_CYCLES = 80;

   // indexes that map to no register
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 3'd7;

   typedef enum logic [2:0] {
      PH_HUNT, PH_START_TWO, PH_TYPE_BYTE, PH_LENGTH, PH_DATA, PH_TRAILER
   } frame_phase_type;

   typedef struct packed {
      logic [7:0]       packet_type;
      logic [LEN_W-1:0] payload_length;
      logic [4:0]       payload_index;
      logic [7:0]       payload_byte;
      logic             has_payload;
      logic             is_confirmation;
      logic             last;
   } frame_word_type;

   class frame_predictor;
      logic [7:0]       start_one;
      logic [7:0]       start_two;
      logic [7:0]       trailer;
      logic [LEN_W-1:0] max_len;
      logic [7:0]       ok_type;
      logic             confirm_en;

      frame_phase_type  phase;
      logic [7:0]       held_two;
      logic [7:0]       held_type;
      logic [LEN_W-1:0] held_len;
      logic [LEN_W-1:0] taken;
      logic [7:0]       buffer [PAYLOAD_DEPTH];

      frame_word_type   pending_words [$];
      int               errors;

      function new();
         start_one  = 8'd85;
         start_two  = 8'd170;
         trailer    = 8'd69;
         max_len    = 6'd23;
         ok_type    = 8'd0;
         confirm_en = 1'b1;
         phase      = PH_HUNT;
         held_two   = '0;
         held_type  = '0;
         held_len   = '0;
         taken      = '0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_START_ONE:  start_one  = data[7:0];
            CSR_START_TWO:  start_two  = data[7:0];
            CSR_TRAILER:    trailer    = data[7:0];
            CSR_MAX_LENGTH: max_len    = data[LEN_W-1:0];
            CSR_OK_TYPE:    ok_type    = data[7:0];
            CSR_CONFIRM_EN: confirm_en = data[0];
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] b);
         frame_word_type w;
         int             n;
         logic           conf;
         case (phase)
            PH_HUNT: begin
               if (b == start_one) phase = PH_START_TWO;
            end
            PH_START_TWO: begin
               held_two = b;
               phase = PH_TYPE_BYTE;
            end
            PH_TYPE_BYTE: begin
               held_type = b;
               phase = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (held_two != start_two || b > {2'b00, max_len} || b > PAYLOAD_DEPTH) begin
                  phase = PH_HUNT;
               end else begin
                  held_len = b[LEN_W-1:0];
                  taken = '0;
                  phase = (b == 8'd0) ? PH_TRAILER : PH_DATA;
               end
            end
            PH_DATA: begin
               if (taken < PAYLOAD_DEPTH) buffer[taken[IDX_W-1:0]] = b;
               taken = taken + 1'b1;
               if (taken >= held_len) phase = PH_TRAILER;
            end
            PH_TRAILER: begin
               if (b == trailer) begin
                  conf = confirm_en && (held_type == ok_type);
                  if (held_len == 0) begin
                     w = {held_type, held_len, 5'd0, 8'd0, 1'b0, conf, 1'b1};
                     pending_words.push_back(w);
                  end else begin
                     n = (held_len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : held_len;
                     for (int i = 0; i < n; i++) begin
                        w = {held_type, held_len, 5'(i), buffer[i], 1'b1, conf,
                             1'(i + 1 == n)};
                        pending_words.push_back(w);
                     end
                  end
               end
               phase = PH_HUNT;
            end
            default: phase = PH_HUNT;
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(frame_word_type got);
         frame_word_type want;
         if (pending_words.size() == 0) begin
            $error("frame word with nothing expected: type %0d index %0d",
                   got.packet_type, got.payload_index);
            errors++;
         end else begin
            want = pending_words.pop_front();
            compare_field("packet_type", want.packet_type, got.packet_type);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("payload_index", want.payload_index, got.payload_index);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("has_payload", want.has_payload, got.has_payload);
            compare_field("is_confirmation", want.is_confirmation, got.is_confirmation);
            compare_field("last", want.last, got.last);
         end
      endfunction

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_packet_type;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [4:0]           rsp_payload_index;
   logic [7:0]           rsp_payload_byte;
   logic                 rsp_has_payload;
   logic                 rsp_is_confirmation;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   frame_predictor sb;
   int send_idle = 0;
   int recv_idle = 0;
   int cycle_count = 0;

   uart_packet_deframer_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_packet_type     (rsp_packet_type),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_has_payload     (rsp_has_payload),
      .rsp_is_confirmation (rsp_is_confirmation),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_word({rsp_packet_type, rsp_payload_length, rsp_payload_index,
                        rsp_payload_byte, rsp_has_payload, rsp_is_confirmation,
                        rsp_last});
      end
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.take_byte(b);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // upper data bits are random so the block has to mask them
   task automatic program_regs(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] tr, input logic [LEN_W-1:0] ml,
                               input logic [7:0] ok, input logic ce);
      csr_write(CSR_START_ONE, {24'($urandom()), s1});
      csr_write(CSR_START_TWO, {24'($urandom()), s2});
      csr_write(CSR_TRAILER, {24'($urandom()), tr});
      csr_write(CSR_MAX_LENGTH, {26'($urandom()), ml});
      csr_write(CSR_OK_TYPE, {24'($urandom()), ok});
      csr_write(CSR_CONFIRM_EN, {31'($urandom()), ce});
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [7:0] seq [$];
      seq = '{
         // empty acknowledge frame
         8'd85, 8'd170, 8'd0, 8'd0, 8'd69,
         // two payload bytes at the byte extremes
         8'd85, 8'd170, 8'd255, 8'd2, 8'd0, 8'd255, 8'd69,
         // wrong second start byte
         8'd85, 8'd18, 8'd7, 8'd1,
         // length one above the bound
         8'd85, 8'd170, 8'd3, 8'd24,
         // wrong trailer drops the frame
         8'd85, 8'd170, 8'd1, 8'd0, 8'd68
      };
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic run_random(input int n_items);
      int         sent;
      int         pick;
      int         lim;
      int         len;
      logic [7:0] ptype;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         lim = (sb.max_len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : sb.max_len;
         ptype = ($urandom_range(3) == 0) ? sb.ok_type : 8'($urandom());
         if (pick < 8) begin
            // noise while hunting
            send_byte(8'($urandom()));
         end else if (pick < 14) begin
            send_byte(sb.start_one);
            send_byte(sb.start_two ^ 8'($urandom_range(1, 255)));
            send_byte(ptype);
            send_byte(8'($urandom()));
            sent += 4;
         end else if (pick < 20) begin
            send_byte(sb.start_one);
            send_byte(sb.start_two);
            send_byte(ptype);
            send_byte(8'($urandom_range(lim + 1, 255)));
            sent += 4;
         end else begin
            if ($urandom_range(9) == 0) len = lim;
            else len = $urandom_range((lim > 8) ? 8 : lim);
            send_byte(sb.start_one);
            send_byte(sb.start_two);
            send_byte(ptype);
            send_byte(8'(len));
            for (int i = 0; i < len; i++) send_byte(8'($urandom()));
            if (pick < 27) send_byte(sb.trailer ^ 8'($urandom_range(1, 255)));
            else send_byte(sb.trailer);
            sent += 5 + len;
         end
      end
   endtask

   initial begin
      sb = new();
      send_idle = 19;
      recv_idle = 62;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(50);
      settle();

      program_regs(8'd0, 8'd255, 8'd0, 6'd0, 8'd255, 1'b0);
      run_random(40);
      settle();

      send_idle = 62;
      recv_idle = 19;
      program_regs(8'd255, 8'd0, 8'd255, 6'd32, 8'd0, 1'b1);
      run_random(60);
      settle();

      csr_write(CSR_UNUSED_A, $urandom());
      csr_write(CSR_UNUSED_B, $urandom());
      program_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), 6'd63,
                   8'($urandom()), 1'b1);
      run_random(55);
      settle();

      send_idle = 0;
      recv_idle = 0;
      program_regs(8'($urandom()), 8'($urandom()), 8'($urandom()),
                   6'($urandom_range(63)), 8'($urandom()), 1'b1);
      run_random(55);
      settle();

      program_regs(8'd85, 8'($urandom()), 8'($urandom()), 6'd32, 8'($urandom()),
                   1'($urandom()));
      run_random(60);
      settle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
